// ===== hdl/mslcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mslcg_pkg
// Shared types and constants for the minimal standard generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mslcg_pkg;

  localparam int unsigned StateW = 31;
  localparam int unsigned IntW   = 32;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned MagW   = 33;

  localparam logic [StateW-1:0] LcgMul   = 31'd16807;
  localparam logic [StateW-1:0] LcgMod   = 31'h7FFF_FFFF;
  localparam logic [StateW-1:0] SeedOne  = 31'd1;
  // half the modulus, rounded down, for round half up
  localparam logic [StateW-1:0] RoundBias = 31'h3FFF_FFFF;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_BELOW = 2'd1,
    OP_RANGE = 2'd2,
    OP_SEED  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_RED1,
    S_MUL2,
    S_FOLD1,
    S_FOLD2,
    S_FIN,
    S_ADJ,
    S_OUT
  } fsm_e;

endpackage

`default_nettype wire

// ===== hdl/minimal_standard_lcg_ranged.sv =====
// ----------------------------------------------------------------------------
// minimal_standard_lcg_ranged
// Park-Miller generator with exact integer scaling, one shared multiplier
// and a Mersenne-modulus fold unit run by a small sequencer.
// ----------------------------------------------------------------------------
// steps: multiply, reduce and output for draw and seed load; integer below bound
//   and integer in range add a second multiply, two fold steps, floor and adjust
// input ready only while the sequencer is idle, so one item ends before the next;
//   one pass through the 31x33 multiplier for the step, for bound and range a second to scale
// a held output beat keeps the sequencer in its last step until it is taken
// reset: generator state comes up as 16807, sequencer idle, no output beat
`timescale 1ns / 1ps
`default_nettype none

module minimal_standard_lcg_ranged
  import mslcg_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // bound[30:0], range_low[62:31], range_high[94:63], new_seed[125:95], zero pad
  input  wire logic [127:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // draw[30:0], int_value[62:31], zero pad [63]
  output logic [63:0]       m_axis_tdata,
  // bad_arg[0]
  output logic              m_axis_tuser
);

  // control
  fsm_e              fsm_q, fsm_d;
  logic [StateW-1:0] lcg_q, lcg_d;
  logic              out_valid_q, out_valid_d;

  // payload
  op_e                      op_q, op_d;
  logic [StateW-1:0]        bound_q, bound_d;
  logic signed [IntW-1:0]   lo_q, lo_d;
  logic signed [IntW-1:0]   hi_q, hi_d;
  logic                     bad_q, bad_d;
  logic                     wneg_q, wneg_d;
  logic [MagW-1:0]          wmag_q, wmag_d;
  logic [ProdW-1:0]         prod_q, prod_d;
  logic [MagW-1:0]          quo_q, quo_d;
  logic [33:0]              sum_q, sum_d;
  logic [MagW-1:0]          uq_q, uq_d;
  logic                     rnz_q, rnz_d;
  logic signed [34:0]       qf_q, qf_d;
  logic [IntW-1:0]          res_q, res_d;
  logic [StateW-1:0]        out_draw_q, out_draw_d;
  logic [IntW-1:0]          out_int_q, out_int_d;
  logic                     out_bad_q, out_bad_d;

  // input field views
  logic [1:0]             in_op;
  logic [StateW-1:0]      in_bound;
  logic signed [IntW-1:0] in_lo;
  logic signed [IntW-1:0] in_hi;
  logic [StateW-1:0]      in_seed;

  assign in_op    = s_axis_tuser;
  assign in_bound = s_axis_tdata[30:0];
  assign in_lo    = s_axis_tdata[62:31];
  assign in_hi    = s_axis_tdata[94:63];
  assign in_seed  = s_axis_tdata[125:95];

  // shared multiplier
  logic [StateW-1:0] mul_a;
  logic [MagW-1:0]   mul_b;
  logic [ProdW-1:0]  mul_p;

  assign mul_a = lcg_q;
  always_comb begin
    if (fsm_q == S_MUL1) begin
      mul_b = {2'b00, LcgMul};
    end else if (op_q == OP_BELOW) begin
      mul_b = {2'b00, bound_q};
    end else begin
      mul_b = wmag_q;
    end
  end
  assign mul_p = {33'd0, mul_a} * {31'd0, mul_b};

  // datapath scratch
  logic [31:0]        step_sum;
  logic signed [33:0] w_pos;
  logic signed [33:0] w_negv;
  logic [2:0]         fold_c;
  logic [31:0]        fold_s;
  logic               fold_ge;
  logic signed [34:0] q_adj;
  logic               accept;

  assign s_axis_tready = (fsm_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    fsm_d       = fsm_q;
    lcg_d       = lcg_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    bound_d     = bound_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    bad_d       = bad_q;
    wneg_d      = wneg_q;
    wmag_d      = wmag_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    sum_d       = sum_q;
    uq_d        = uq_q;
    rnz_d       = rnz_q;
    qf_d        = qf_q;
    res_d       = res_q;
    out_draw_d  = out_draw_q;
    out_int_d   = out_int_q;
    out_bad_d   = out_bad_q;

    step_sum = {1'b0, prod_q[30:0]} + {17'd0, prod_q[45:31]};
    w_pos    = 34'(hi_q) - 34'(lo_q) + 34'sd1;
    w_negv   = 34'(lo_q) - 34'(hi_q) - 34'sd1;
    fold_c   = sum_q[33:31];
    fold_s   = {1'b0, sum_q[30:0]} + {29'd0, fold_c};
    fold_ge  = fold_s >= {1'b0, LcgMod};
    q_adj    = qf_q + 35'((qf_q < 0) && rnz_q);

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (fsm_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(in_op);
          bound_d = in_bound;
          lo_d    = in_lo;
          hi_d    = in_hi;
          bad_d   = 1'b0;
          if (op_e'(in_op) == OP_SEED) begin
            if (in_seed == '0 || in_seed == LcgMod) begin
              bad_d = 1'b1;
              lcg_d = SeedOne;
            end else begin
              lcg_d = in_seed;
            end
          end else if (op_e'(in_op) == OP_RANGE) begin
            bad_d = in_hi < in_lo;
          end
          fsm_d = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_d = mul_p;
        wneg_d = w_pos[33];
        wmag_d = w_pos[33] ? w_negv[32:0] : w_pos[32:0];
        fsm_d  = S_RED1;
      end
      S_RED1: begin
        // 2^31 = 1 mod m, so fold the high part onto the low part
        lcg_d = (step_sum >= {1'b0, LcgMod}) ? 31'(step_sum - {1'b0, LcgMod})
                                              : step_sum[30:0];
        res_d = '0;
        if (op_q == OP_BELOW || op_q == OP_RANGE) begin
          fsm_d = S_MUL2;
        end else begin
          fsm_d = S_OUT;
        end
      end
      S_MUL2: begin
        prod_d = mul_p;
        fsm_d  = S_FOLD1;
      end
      S_FOLD1: begin
        quo_d = prod_q[63:31];
        sum_d = {3'd0, prod_q[30:0]} + {1'b0, prod_q[63:31]}
              + ((op_q == OP_BELOW) ? {3'd0, RoundBias} : 34'd0);
        fsm_d = S_FOLD2;
      end
      S_FOLD2: begin
        uq_d  = quo_q + {30'd0, fold_c} + {32'd0, fold_ge};
        rnz_d = (fold_s != '0) && (fold_s != {1'b0, LcgMod});
        fsm_d = S_FIN;
      end
      S_FIN: begin
        // negative product: floor = -uq - (rem != 0)
        qf_d  = 35'(lo_q) + (wneg_q ? ~{2'b00, uq_q} : {2'b00, uq_q})
              + 35'(wneg_q && !rnz_q);
        fsm_d = S_ADJ;
      end
      S_ADJ: begin
        if (op_q == OP_BELOW) begin
          res_d = (uq_q == {2'b00, bound_q}) ? '0 : uq_q[31:0];
        end else if (q_adj > 35'(hi_q)) begin
          res_d = lo_q;
        end else begin
          res_d = q_adj[31:0];
        end
        fsm_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_draw_d  = lcg_q;
          out_int_d   = res_q;
          out_bad_d   = bad_q;
          fsm_d       = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      lcg_q       <= LcgMul;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      lcg_q       <= lcg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    bound_q    <= bound_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    bad_q      <= bad_d;
    wneg_q     <= wneg_d;
    wmag_q     <= wmag_d;
    prod_q     <= prod_d;
    quo_q      <= quo_d;
    sum_q      <= sum_d;
    uq_q       <= uq_d;
    rnz_q      <= rnz_d;
    qf_q       <= qf_d;
    res_q      <= res_d;
    out_draw_q <= out_draw_d;
    out_int_q  <= out_int_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_int_q, out_draw_q};
  assign m_axis_tuser  = out_bad_q;

  // generator state never leaves 1 .. m-1 once a step is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_OUT) |-> (lcg_q != '0 && lcg_q != LcgMod))
    else $error("generator state out of range");

  // integer below bound stays below a nonzero bound and is zero for a zero bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_OUT && op_q == OP_BELOW) |->
      ((bound_q != '0 && res_q < {1'b0, bound_q}) || (bound_q == '0 && res_q == '0)))
    else $error("bounded integer out of range");

  // integer in a proper range lies between its ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_OUT && op_q == OP_RANGE && !bad_q) |->
      ($signed(res_q) >= lo_q && $signed(res_q) <= hi_q))
    else $error("ranged integer outside range");

endmodule

`default_nettype wire

// ===== verif/minimal_standard_lcg_ranged_tb.sv =====
// ----------------------------------------------------------------------------
// minimal_standard_lcg_ranged_tb
// Self-checking bench for the Park-Miller generator with integer scaling.
// A short table of directed beats (seed edge cases, field extremes, empty
// ranges) is followed by random beats. Every accepted input beat runs through
// a behavioral model of the generator, and every output beat is compared
// field by field with the oldest predicted result. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minimal_standard_lcg_ranged_tb;
  import mslcg_pkg::*;

  localparam int unsigned NumRandom = 1932;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ShowLimit = 10;
  localparam longint      IntMax    = 64'sd2147483647;

  typedef struct packed {
    logic [30:0]        draw;
    logic signed [31:0] int_value;
    logic               bad_arg;
  } draw_rsp_t;

  typedef struct packed {
    op_e                op;
    logic [30:0]        bound;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        seed;
    logic               fixed;    // typed-in result below is used
    draw_rsp_t          res;
  } stim_row_t;

  // directed rows; the known results follow from reset or a fresh seed load
  localparam int unsigned NumDirected = 18;
  localparam stim_row_t DirRows [NumDirected] = '{
    '{OP_DRAW,  31'd0, 32'sd0, 32'sd0, 31'd0, 1'b1, '{31'd282475249, 32'sd0, 1'b0}},
    '{OP_SEED,  31'd0, 32'sd0, 32'sd0, 31'd0, 1'b1, '{31'd16807, 32'sd0, 1'b1}},
    '{OP_SEED,  31'd0, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 1'b1, '{31'd16807, 32'sd0, 1'b1}},
    '{OP_SEED,  31'd0, 32'sd0, 32'sd0, 31'd1, 1'b1, '{31'd16807, 32'sd0, 1'b0}},
    '{OP_BELOW, 31'd0, 32'sd0, 32'sd0, 31'd0, 1'b1, '{31'd282475249, 32'sd0, 1'b0}},
    '{OP_SEED,  31'd0, 32'sd0, 32'sd0, 31'h7FFF_FFFE, 1'b1,
      '{31'd2147466840, 32'sd0, 1'b0}},
    '{OP_RANGE, 31'd0, 32'sd5, 32'sd5, 31'd0, 1'b1, '{31'd1865008398, 32'sd5, 1'b0}},
    '{OP_BELOW, 31'd1, 32'sd0, 32'sd0, 31'd0, 1'b0, '0},
    '{OP_BELOW, 31'h7FFF_FFFF, 32'sd0, 32'sd0, 31'd0, 1'b0, '0},
    '{OP_BELOW, 31'd6, 32'sd0, 32'sd0, 31'd0, 1'b0, '0},
    '{OP_RANGE, 31'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd0, 1'b0, '0},
    '{OP_RANGE, 31'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0, 1'b0, '0},
    '{OP_RANGE, 31'd0, 32'sh8000_0000, 32'sh8000_0000, 31'd0, 1'b0, '0},
    '{OP_RANGE, 31'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0, 1'b0, '0},
    '{OP_RANGE, 31'd0, 32'sd10, -32'sd10, 31'd0, 1'b0, '0},
    '{OP_RANGE, 31'd0, -32'sd7, 32'sd3, 31'd0, 1'b0, '0},
    // unused fields, all ones or mixed patterns, must not matter
    '{OP_DRAW,  31'h7FFF_FFFF, -32'sd1, -32'sd1, 31'h7FFF_FFFF, 1'b0, '0},
    '{OP_SEED,  31'h5555_5555, 32'sh2AAA_AAAA, -32'sd99, 31'd12345, 1'b0, '0}
  };

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid;
  logic [127:0] in_data;
  logic [1:0]   in_op;
  logic         out_ready;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  logic        [30:0] gen_state;
  draw_rsp_t          pending_draws [$];
  stim_row_t          cur_row;
  logic               calm;
  int unsigned        err_count;
  int unsigned        shown;
  int unsigned        idle_cycles;
  int unsigned        op_count [4];
  int unsigned        rsp_count;
  int unsigned        empty_ranges;
  int unsigned        rejected_seeds;

  minimal_standard_lcg_ranged u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // advances the generator model and scales the new draw
  function automatic draw_rsp_t next_draw(input op_e op, input logic [30:0] bound,
                                          input logic signed [31:0] lo,
                                          input logic signed [31:0] hi,
                                          input logic [30:0] seed);
    draw_rsp_t       r;
    logic [30:0]     base;
    longint unsigned prod;
    longint unsigned num_u;
    longint unsigned q_u;
    longint          mod_l;
    longint          d_l;
    longint          lo_l;
    longint          hi_l;
    longint          q;
    r = '0;
    base = gen_state;
    if (op == OP_SEED) begin
      if (seed == 31'd0 || seed == LcgMod) begin
        r.bad_arg = 1'b1;
        base = SeedOne;
      end else begin
        base = seed;
      end
    end
    prod = 64'(base) * 64'(LcgMul);
    gen_state = 31'(prod % 64'(LcgMod));
    r.draw = gen_state;
    case (op)
      OP_BELOW: begin
        // draw*bound/M rounded half up, a hit on bound wraps to zero
        num_u = 64'd2 * 64'(gen_state) * 64'(bound) + 64'(LcgMod);
        q_u = num_u / (64'd2 * 64'(LcgMod));
        if (q_u == 64'(bound)) q_u = 0;
        r.int_value = q_u[31:0];
      end
      OP_RANGE: begin
        mod_l = longint'(64'(LcgMod));
        d_l = longint'(64'(gen_state));
        lo_l = longint'(lo);
        hi_l = longint'(hi);
        q = (lo_l * (mod_l - d_l) + d_l * (hi_l + 1)) / mod_l;
        if (hi_l < lo_l) r.bad_arg = 1'b1;
        if (q > hi_l) q = lo_l;
        r.int_value = q[31:0];
      end
      default: r.int_value = '0;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic signed [31:0] extreme_int();
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    longint    other;
    r = '0;
    r.op = op_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.bound = 31'($urandom_range(0, 16));
      8:          r.bound = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h7FFF_FFFE;
      9:          r.bound = 31'd1 << $urandom_range(0, 30);
      default:    r.bound = 31'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r.lo = $urandom;
        other = longint'(r.lo) + longint'($urandom_range(0, 20));
        if (other > IntMax) other = IntMax;
        r.hi = other[31:0];
      end
      6: begin
        // empty range, low end just above high end
        r.hi = $urandom;
        other = longint'(r.hi) + longint'($urandom_range(1, 20));
        if (other > IntMax) other = IntMax;
        r.lo = other[31:0];
      end
      7: begin
        r.lo = extreme_int();
        r.hi = extreme_int();
      end
      8, 9: begin
        r.lo = 32'sd0 - 32'($urandom_range(0, 50));
        r.hi = 32'($urandom_range(0, 50));
      end
      default: begin
        r.lo = $urandom;
        r.hi = $urandom;
      end
    endcase
    if ($urandom_range(0, 15) == 0) r.seed = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
    else r.seed = 31'($urandom_range(1, 32'h7FFF_FFFE));
    return r;
  endfunction

  task automatic send_beat(input stim_row_t row);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {2'b00, row.seed, row.hi, row.lo, row.bound};
    in_op    <= row.op;
    cur_row = row;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold the input side until the generator has drained
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // input and output beat checker
  always @(posedge clk_i) begin
    draw_rsp_t pred;
    draw_rsp_t got;
    op_e       op;
    if (rst_ni) begin
      if (in_valid && s_axis_tready) begin
        op = op_e'(in_op);
        pred = next_draw(op, in_data[30:0], in_data[62:31], in_data[94:63],
                         in_data[125:95]);
        pending_draws.push_back(cur_row.fixed ? cur_row.res : pred);
        op_count[op]++;
        if (op == OP_RANGE && pred.bad_arg) empty_ranges++;
        if (op == OP_SEED && pred.bad_arg) rejected_seeds++;
      end
      if (m_axis_tvalid && out_ready) begin
        rsp_count++;
        got.draw      = m_axis_tdata[30:0];
        got.int_value = m_axis_tdata[62:31];
        got.bad_arg   = m_axis_tuser;
        if (pending_draws.size() == 0) begin
          err_count++;
          if (shown < ShowLimit) begin
            shown++;
            $display("unexpected output beat: draw %0d int %0d bad %0b",
                     got.draw, got.int_value, got.bad_arg);
          end
        end else begin
          pred = pending_draws.pop_front();
          if (got != pred) begin
            err_count++;
            if (shown < ShowLimit) begin
              shown++;
              $display("mismatch on result %0d: expected draw %0d int %0d bad %0b,",
                       rsp_count, pred.draw, pred.int_value, pred.bad_arg);
              $display("  got draw %0d int %0d bad %0b",
                       got.draw, got.int_value, got.bad_arg);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && s_axis_tready) || (m_axis_tvalid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending_draws.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side ready pattern
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    in_op          = '0;
    cur_row        = '0;
    calm           = 1'b0;
    gen_state      = LcgMul;
    err_count      = 0;
    shown          = 0;
    idle_cycles    = 0;
    rsp_count      = 0;
    empty_ranges   = 0;
    rejected_seeds = 0;
    op_count       = '{default: 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_beat(DirRows[i]);
    drain_results();

    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 200 && i < 350) || (i >= 1500 && i < 1600);
      if (i == 700 || i == 1300) drain_results();
      send_beat(random_row());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_draws.size() != 0) err_count++;

    $display("%0d items: %0d draws, %0d bounded, %0d ranged (%0d empty), %0d seed loads",
             NumDirected + NumRandom, op_count[OP_DRAW], op_count[OP_BELOW],
             op_count[OP_RANGE], empty_ranges, op_count[OP_SEED]);
    $display("%0d results compared, %0d rejected seeds, %0d failures",
             rsp_count, rejected_seeds, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mslcg_pkg.sv
hdl/minimal_standard_lcg_ranged.sv
verif/minimal_standard_lcg_ranged_tb.sv
